// ===== hdl/ppp3_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ppp3_pkg
// Shared types and constants of the ASCII PPM (P3) parser.
// ============================================================================
package ppp3_pkg;

    // Result codes carried in the kind field.
    typedef enum logic [1:0] {
        KIND_PIXEL     = 2'd0,
        KIND_BAD_MAGIC = 2'd1,
        KIND_BAD_MAX   = 2'd2
    } t_kind;

    localparam logic [7:0] CHAR_P       = 8'h50;  // 'P'
    localparam logic [7:0] CHAR_THREE   = 8'h33;  // '3'
    localparam logic [7:0] CHAR_HASH    = 8'h23;  // '#'
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;  // '\n'
    localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE    = 8'h39;  // '9'

    localparam logic [31:0] MAX_VALUE     = 32'd255;
    localparam logic [1:0]  LAST_CHANNEL  = 2'd2;
    localparam int          CHANNEL_BITS  = 8;
    localparam int          ORIGIN_WIDTH  = 16;
    localparam int          CFG_IDX_WIDTH = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_X_ORIGIN = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_Y_ORIGIN = 1'd1;

    // One parser result as produced by the core for a single byte.
    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] color;
    } t_result;

endpackage

// ===== hdl/ppp3_in_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ppp3_in_if
// Byte channel into the parser: valid, ready and one file byte per item.
// ============================================================================
interface ppp3_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       start_req;

    modport source (output valid, output file_byte, output start_req, input ready);
    modport sink   (input valid, input file_byte, input start_req, output ready);
endinterface

// ===== hdl/ppp3_out_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ppp3_out_if
// Result channel out of the parser: pixel or error items.
// ============================================================================
interface ppp3_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [31:0] pixel_color;

    modport source (output valid, output kind, output pixel_x, output pixel_y,
                    output pixel_color, input ready);
    modport sink   (input valid, input kind, input pixel_x, input pixel_y,
                    input pixel_color, output ready);
endinterface

// ===== hdl/ppm_p3_text_image_parser.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ppm_p3_text_image_parser
// Streams an ASCII PPM (P3) file byte by byte and emits screen pixels or error results.
// ============================================================================
//
//  Channel    Direction  Handshake     Payload
//  i_in       in         valid/ready   file_byte[7:0], start_req
//  o_out      out        valid/ready   kind[1:0], pixel_x/y[15:0], pixel_color[31:0]
//  cfg        in         write enable  i_cfg_idx, i_cfg_wdata[15:0]
//
// Each item passes through an input register and then the parser logic, whose
// result lands in the output register, from which it is presented. One item is
// taken per cycle whenever the output register is empty or being drained; the
// output register alone sets the rate. A stall on the output side holds the
// input register, and the input side then drops ready. Reset is synchronous
// and clears the parser and both origins.
//
module ppm_p3_text_image_parser
    import ppp3_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ppp3_in_if.sink                  i_in,
    ppp3_out_if.source               o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [ORIGIN_WIDTH-1:0]  i_cfg_wdata
);

    // Screen origin registers.
    logic [15:0] r_x_origin;
    logic [15:0] r_y_origin;

    // Input stage.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // Output stage.
    logic    r_out_valid;
    t_result r_out;

    logic    advance;
    logic    in_fire;
    t_result core_res;

    // The input item moves on when the output register has room for a result.
    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_fire = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= '0;
            r_y_origin <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_ORIGIN: r_x_origin <= i_cfg_wdata;
                CFG_Y_ORIGIN: r_y_origin <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte  <= i_in.file_byte;
            r_in_start <= i_in.start_req;
        end
    end

    ppp3_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_byte     (r_in_byte),
        .i_start    (r_in_start),
        .i_x_origin (r_x_origin),
        .i_y_origin (r_y_origin),
        .o_result   (core_res)
    );

    // Bytes that give no result leave the output register untouched unless it
    // is being drained in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= core_res.valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_res.valid) begin
            r_out <= core_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.pixel_x     = r_out.x;
    assign o_out.pixel_y     = r_out.y;
    assign o_out.pixel_color = r_out.color;

    // Error results carry an all-zero payload.
    a_error_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind != KIND_PIXEL)) |->
        (r_out.x == 16'd0 && r_out.y == 16'd0 && r_out.color == 32'd0))
        else $error("error result with nonzero payload");

    // A blocked input stage keeps its byte until the output side frees up.
    a_in_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)
        && $stable(r_in_start)))
        else $error("input stage lost a stalled item");

    // A drained result with nothing new behind it empties the output stage.
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_out.ready && !(advance && core_res.valid)) |=> !r_out_valid)
        else $error("output stage repeated a taken result");

endmodule

// ===== hdl/ppp3_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ppp3_core
// Parser state and the per-byte next-state and result logic.
// ============================================================================
module ppp3_core
    import ppp3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_start,
    input  logic [15:0] i_x_origin,
    input  logic [15:0] i_y_origin,
    output t_result     o_result
);

    typedef enum logic [1:0] {
        POS_MAGIC0,
        POS_MAGIC1,
        POS_SKIP,
        POS_BODY
    } t_pos;

    t_pos        r_pos, n_pos, c_pos;
    logic        r_halted, n_halted, c_halted;
    logic        r_comment, n_comment, c_comment;
    logic        r_active, n_active, c_active;
    logic [31:0] r_acc, n_acc, c_acc;
    logic [15:0] r_width, n_width, c_width;
    logic [15:0] r_height, n_height, c_height;
    logic        r_max_seen, n_max_seen, c_max_seen;
    logic [1:0]  r_chan, n_chan, c_chan;
    logic [31:0] r_color, n_color, c_color;
    logic [15:0] r_col, n_col, c_col;
    logic [15:0] r_row, n_row, c_row;

    logic        is_digit;
    logic [3:0]  digit;
    logic [15:0] num_sat;
    logic [15:0] col_inc;
    t_result     res;

    assign is_digit = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign digit    = 4'(i_byte - CHAR_ZERO);
    assign num_sat  = (c_acc[31:16] != 16'd0) ? 16'hFFFF : c_acc[15:0];
    assign col_inc  = c_col + 16'd1;

    always_comb begin
        // A start flag clears the parser before its byte is handled.
        c_pos      = i_start ? POS_MAGIC0 : r_pos;
        c_halted   = i_start ? 1'b0  : r_halted;
        c_comment  = i_start ? 1'b0  : r_comment;
        c_active   = i_start ? 1'b0  : r_active;
        c_acc      = i_start ? '0    : r_acc;
        c_width    = i_start ? '0    : r_width;
        c_height   = i_start ? '0    : r_height;
        c_max_seen = i_start ? 1'b0  : r_max_seen;
        c_chan     = i_start ? '0    : r_chan;
        c_color    = i_start ? '0    : r_color;
        c_col      = i_start ? '0    : r_col;
        c_row      = i_start ? '0    : r_row;

        n_pos      = c_pos;
        n_halted   = c_halted;
        n_comment  = c_comment;
        n_active   = c_active;
        n_acc      = c_acc;
        n_width    = c_width;
        n_height   = c_height;
        n_max_seen = c_max_seen;
        n_chan     = c_chan;
        n_color    = c_color;
        n_col      = c_col;
        n_row      = c_row;
        res        = '0;

        if (!c_halted) begin
            case (c_pos)
                POS_MAGIC0: begin
                    n_pos = POS_MAGIC1;
                    if (i_byte != CHAR_P) begin
                        n_halted  = 1'b1;
                        res.valid = 1'b1;
                        res.kind  = KIND_BAD_MAGIC;
                    end
                end
                POS_MAGIC1: begin
                    n_pos = POS_SKIP;
                    if (i_byte != CHAR_THREE) begin
                        n_halted  = 1'b1;
                        res.valid = 1'b1;
                        res.kind  = KIND_BAD_MAGIC;
                    end
                end
                POS_SKIP: begin
                    n_pos = POS_BODY;
                end
                POS_BODY: begin
                    if (c_comment) begin
                        if (i_byte == CHAR_NEWLINE) begin
                            n_comment = 1'b0;
                        end
                    end else if (i_byte == CHAR_HASH) begin
                        n_comment = 1'b1;
                    end else if (is_digit) begin
                        n_active = 1'b1;
                        n_acc    = (c_acc << 3) + (c_acc << 1) + {28'd0, digit};
                    end else if (c_active) begin
                        // A separator commits the number just built.
                        n_active = 1'b0;
                        n_acc    = '0;
                        if (c_width == 16'd0) begin
                            n_width = num_sat;
                        end else if (c_height == 16'd0) begin
                            n_height = num_sat;
                        end else if (!c_max_seen) begin
                            if (c_acc != MAX_VALUE) begin
                                n_halted  = 1'b1;
                                res.valid = 1'b1;
                                res.kind  = KIND_BAD_MAX;
                            end else begin
                                n_max_seen = 1'b1;
                            end
                        end else begin
                            n_color = (c_color << CHANNEL_BITS) | c_acc;
                            if (c_chan == LAST_CHANNEL) begin
                                n_chan    = '0;
                                res.valid = 1'b1;
                                res.kind  = KIND_PIXEL;
                                res.x     = i_x_origin + c_col;
                                res.y     = i_y_origin + c_row;
                                res.color = n_color;
                                if (col_inc >= c_width) begin
                                    n_col = '0;
                                    n_row = c_row + 16'd1;
                                end else begin
                                    n_col = col_inc;
                                end
                            end else begin
                                n_chan = c_chan + 2'd1;
                            end
                        end
                    end
                end
                default: begin
                    n_pos = POS_MAGIC0;
                end
            endcase
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_MAGIC0;
            r_halted   <= 1'b0;
            r_comment  <= 1'b0;
            r_active   <= 1'b0;
            r_acc      <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_max_seen <= 1'b0;
            r_chan     <= '0;
            r_color    <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_halted   <= n_halted;
            r_comment  <= n_comment;
            r_active   <= n_active;
            r_acc      <= n_acc;
            r_width    <= n_width;
            r_height   <= n_height;
            r_max_seen <= n_max_seen;
            r_chan     <= n_chan;
            r_color    <= n_color;
            r_col      <= n_col;
            r_row      <= n_row;
        end
    end

endmodule
